[hdl/park_miller_random_in_range_top_assert.svh]
// ----------------------------------------------------------------------------
// park_miller_random_in_range_top_assert.svh
// assertion macros shared by the random-in-range block
// ----------------------------------------------------------------------------
`ifndef PARK_MILLER_RANDOM_IN_RANGE_TOP_ASSERT_SVH
`define PARK_MILLER_RANDOM_IN_RANGE_TOP_ASSERT_SVH

// same-cycle implication
`define PMR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PMR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pmr_pkg.sv]
// ----------------------------------------------------------------------------
// pmr_pkg
// types, constants and the modular fold of the minimal-standard generator
// ----------------------------------------------------------------------------
package pmr_pkg;

	localparam int SpanW  = 16;
	localparam int StateW = 32;

	localparam logic [30:0] LcgMul = 31'd16807;
	localparam logic [31:0] LcgMod = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [SpanW-1:0] span;
		logic             zero;
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_FOLD_A,
		ST_FOLD_B,
		ST_DIV,
		ST_DONE
	} state_t;

	function automatic logic [StateW-1:0] fold(input logic [StateW-1:0] x);
		if (x > LcgMod) begin
			return (x & LcgMod) + 32'd1;
		end
		return x;
	endfunction

endpackage

[hdl/park_miller_random_in_range_top.sv]
// ----------------------------------------------------------------------------
// park_miller_random_in_range_top
// Minimal-standard (16807, 2^31-1) random generator returning a value below a
// requested span. Each item pushed advances the 32-bit state by one increment
// and a split-and-fold multiply, then reduces the low SPAN_BITS bits of the
// new state modulo span; a zero span gives value 0 with span_error set. Items
// are processed one at a time: a nonzero span passes through the multiply and
// fold states of the back end and then the restoring divider, which retires
// one quotient bit per cycle; a zero span skips the divider. Either one
// waits further while the output register still holds an
// unpopped result. A two-entry input queue and the output register let
// pushes and pops continue while an item is in work. Writing seed loads the
// state directly; state resets to zero.
// ----------------------------------------------------------------------------
module park_miller_random_in_range_top #(
	parameter int SPAN_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         seed_we,
	input  logic [pmr_pkg::StateW-1:0]   seed,
	input  logic                         push,
	output logic                         full,
	input  logic [pmr_pkg::SpanW-1:0]    span,
	output logic                         empty,
	input  logic                         pop,
	output logic [pmr_pkg::SpanW-1:0]    value,
	output logic [pmr_pkg::StateW-1:0]   raw_state,
	output logic                         span_error
);

	logic          req_valid;
	logic          req_pop;
	pmr_pkg::req_t req;

	pmr_front #(
		.SPAN_BITS (SPAN_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.span      (span),
		.req_valid (req_valid),
		.req       (req),
		.req_pop   (req_pop)
	);

	pmr_back #(
		.SPAN_BITS (SPAN_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed       (seed),
		.req_valid  (req_valid),
		.req        (req),
		.req_pop    (req_pop),
		.empty      (empty),
		.pop        (pop),
		.value      (value),
		.raw_state  (raw_state),
		.span_error (span_error)
	);

endmodule

[hdl/pmr_front.sv]
// ----------------------------------------------------------------------------
// pmr_front
// accepts span items, masks and flags zero spans, holds them in a two-entry queue
// ----------------------------------------------------------------------------
`include "park_miller_random_in_range_top_assert.svh"

module pmr_front #(
	parameter int SPAN_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [pmr_pkg::SpanW-1:0]   span,
	output logic                        req_valid,
	output pmr_pkg::req_t               req,
	input  logic                        req_pop
);

	localparam int Depth = 2;
	localparam int PtrW  = $clog2(Depth);
	localparam int CntW  = $clog2(Depth + 1);
	localparam logic [pmr_pkg::SpanW-1:0] SpanMask = (SPAN_BITS >= pmr_pkg::SpanW) ?
		{pmr_pkg::SpanW{1'b1}} : pmr_pkg::SpanW'((64'd1 << SPAN_BITS) - 64'd1);

	pmr_pkg::req_t          req_in;
	pmr_pkg::req_t          entry_q [Depth];
	logic [PtrW-1:0]        wr_ptr_q;
	logic [PtrW-1:0]        rd_ptr_q;
	logic [CntW-1:0]        count_q;
	logic                   wr;
	logic                   rd;

	// classify
	always_comb begin
		req_in.span = span & SpanMask;
		req_in.zero = ((span & SpanMask) == '0);
	end

	assign full      = (count_q == CntW'(Depth));
	assign req_valid = (count_q != '0);
	assign req       = entry_q[rd_ptr_q];
	assign wr        = push && !full;
	assign rd        = req_pop && req_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			unique case ({wr, rd})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	`PMR_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, count_q <= CntW'(Depth), "queue count overflow")
	`PMR_ASSERT_NEXT(a_cnt_inc, clk, arst_n, wr && !rd, count_q == $past(count_q) + CntW'(1), "queue count did not grow")
	`PMR_ASSERT_NEXT(a_cnt_dec, clk, arst_n, rd && !wr, count_q == $past(count_q) - CntW'(1), "queue count did not shrink")

endmodule

[hdl/pmr_back.sv]
// ----------------------------------------------------------------------------
// pmr_back
// advances the generator with one shared multiplier, reduces by a restoring
// divider and holds the result in an output register
// ----------------------------------------------------------------------------
`include "park_miller_random_in_range_top_assert.svh"

module pmr_back #(
	parameter int SPAN_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         seed_we,
	input  logic [pmr_pkg::StateW-1:0]   seed,
	input  logic                         req_valid,
	input  pmr_pkg::req_t                req,
	output logic                         req_pop,
	output logic                         empty,
	input  logic                         pop,
	output logic [pmr_pkg::SpanW-1:0]    value,
	output logic [pmr_pkg::StateW-1:0]   raw_state,
	output logic                         span_error
);

	localparam int CntW = (SPAN_BITS > 1) ? $clog2(SPAN_BITS) : 1;
	localparam logic [CntW-1:0] LastCnt = CntW'(SPAN_BITS - 1);

	pmr_pkg::state_t               state_q;
	pmr_pkg::state_t               state_d;
	pmr_pkg::req_t                 req_q;
	logic [pmr_pkg::StateW-1:0]    gen_q;
	logic [pmr_pkg::StateW-1:0]    s_q;
	logic [pmr_pkg::StateW-1:0]    lo_q;
	logic [30:0]                   hi_q;
	logic [SPAN_BITS-1:0]          dvd_q;
	logic [pmr_pkg::SpanW-1:0]     rem_q;
	logic [CntW-1:0]               cnt_q;
	logic                          out_valid_q;
	logic [pmr_pkg::SpanW-1:0]     value_q;
	logic [pmr_pkg::StateW-1:0]    raw_state_q;
	logic                          span_error_q;

	logic                          out_free;
	logic                          out_load;
	logic [15:0]                   mul_op;
	logic [30:0]                   prod;
	logic [pmr_pkg::StateW-1:0]    fold_in;
	logic [pmr_pkg::StateW-1:0]    folded;
	logic [pmr_pkg::SpanW:0]       shifted;
	logic                          fits;

	assign out_free = !out_valid_q || pop;

	always_comb begin
		state_d  = state_q;
		req_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			pmr_pkg::ST_IDLE: begin
				if (req_valid) begin
					req_pop = 1'b1;
					state_d = pmr_pkg::ST_MUL_LO;
				end
			end
			pmr_pkg::ST_MUL_LO: state_d = pmr_pkg::ST_MUL_HI;
			pmr_pkg::ST_MUL_HI: state_d = pmr_pkg::ST_FOLD_A;
			pmr_pkg::ST_FOLD_A: state_d = pmr_pkg::ST_FOLD_B;
			pmr_pkg::ST_FOLD_B: state_d = req_q.zero ? pmr_pkg::ST_DONE : pmr_pkg::ST_DIV;
			pmr_pkg::ST_DIV: begin
				if (cnt_q == LastCnt) begin
					state_d = pmr_pkg::ST_DONE;
				end
			end
			pmr_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = pmr_pkg::ST_IDLE;
				end
			end
			default: state_d = pmr_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pmr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shared multiplier: low half then high half
	assign mul_op = (state_q == pmr_pkg::ST_MUL_LO) ? s_q[15:0] : s_q[31:16];
	assign prod   = pmr_pkg::LcgMul * {15'd0, mul_op};

	assign fold_in = (state_q == pmr_pkg::ST_FOLD_A) ?
		lo_q + {1'b0, hi_q[14:0], 16'h0000} :
		lo_q + {16'h0000, hi_q[30:15]};
	assign folded  = pmr_pkg::fold(fold_in);

	// restoring divider step
	assign shifted = {rem_q, dvd_q[SPAN_BITS-1]};
	assign fits    = (shifted >= {1'b0, req_q.span});

	always_ff @(posedge clk) begin
		unique case (state_q)
			pmr_pkg::ST_IDLE: begin
				if (req_pop) begin
					req_q <= req;
					s_q   <= gen_q + 32'd1;
				end
			end
			pmr_pkg::ST_MUL_LO: lo_q <= {1'b0, prod};
			pmr_pkg::ST_MUL_HI: hi_q <= prod;
			pmr_pkg::ST_FOLD_A: lo_q <= folded;
			pmr_pkg::ST_FOLD_B: begin
				dvd_q <= folded[SPAN_BITS-1:0];
				rem_q <= '0;
				cnt_q <= '0;
			end
			pmr_pkg::ST_DIV: begin
				rem_q <= fits ? pmr_pkg::SpanW'(shifted - {1'b0, req_q.span}) :
					shifted[pmr_pkg::SpanW-1:0];
				dvd_q <= dvd_q << 1;
				cnt_q <= cnt_q + CntW'(1);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			value_q      <= req_q.zero ? '0 : rem_q;
			raw_state_q  <= gen_q;
			span_error_q <= req_q.zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
		end else if (seed_we) begin
			gen_q <= seed;
		end else if (state_q == pmr_pkg::ST_FOLD_B) begin
			gen_q <= folded;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	assign empty      = !out_valid_q;
	assign value      = value_q;
	assign raw_state  = raw_state_q;
	assign span_error = span_error_q;

	`PMR_ASSERT_SAME(a_div_nonzero, clk, arst_n, state_q == pmr_pkg::ST_DIV, !req_q.zero, "divider running on zero span")
	`PMR_ASSERT_NEXT(a_done_loads, clk, arst_n, (state_q == pmr_pkg::ST_DONE) && out_free, out_valid_q && (state_q == pmr_pkg::ST_IDLE), "result not loaded")
	`PMR_ASSERT_SAME(a_err_value, clk, arst_n, out_valid_q && span_error_q, value_q == '0, "error result with nonzero value")

endmodule
